>>> hw/rtl/wfrra_pkg.sv
// ----------------------------------------------------------------------------
// wfrra_pkg
// Shared constants and helpers for the write-first round-robin read arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package wfrra_pkg;

  localparam int THREADS_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ADDR_BITS_DEF   = 32;
  localparam int TIME_BITS_DEF   = 32;

  localparam int MODE_W   = 2;
  localparam int THREAD_W = 2;
  localparam int CMD_W    = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ_WR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_RD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRANT  = 2'd2;

  // payload fields without the mode, rounded up to whole bytes
  function automatic int in_data_w(int addr_bits, int time_bits);
    return ((THREAD_W + addr_bits + time_bits + CMD_W + 7) / 8) * 8;
  endfunction

  // granted, thread, is_write, address, time, command, refused
  function automatic int out_data_w(int addr_bits, int time_bits);
    return ((1 + THREAD_W + 1 + addr_bits + time_bits + CMD_W + 1 + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/write_first_rr_oldest_read_arbiter.sv
// ----------------------------------------------------------------------------
// write_first_rr_oldest_read_arbiter
// Per-thread write and read queues with a write-first, oldest-read grant.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser carries the mode (enqueue write,
//           enqueue read, grant). in_tdata carries thread, address, arrival
//           time and command. Every item yields exactly one result on out_*.
//   out_* : granted, thread, is_write, address, arrival time, command and
//           the refused flag of a dropped enqueue, all in out_tdata.
//   A grant scans threads from the one after the last winner: the first
//   thread with a write wins, else the read with the smallest head time,
//   ties to the earlier thread in that order.
//   out_tvalid rises once the item has sat in the input register and one
//   pass of decision logic has filled the result register.
//   One item is taken every cycle while the result is not stalled; each queue keeps its head entry in a
//   register read ahead from its memory, so the decision never waits on a
//   memory read.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item before in_tready drops.
//   Reset empties every queue and points the round robin at the last thread;
//   queue memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module write_first_rr_oldest_read_arbiter #(
  parameter int THREADS     = wfrra_pkg::THREADS_DEF,
  parameter int QUEUE_DEPTH = wfrra_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = wfrra_pkg::ADDR_BITS_DEF,
  parameter int TIME_BITS   = wfrra_pkg::TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // thread, address, arrival_time, command
  input  wire logic [wfrra_pkg::in_data_w(ADDR_BITS, TIME_BITS)-1:0] in_tdata,
  // mode
  input  wire logic [wfrra_pkg::MODE_W-1:0] in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // granted, grant_thread, grant_is_write, grant_address, grant_arrival_time,
  // grant_command, enqueue_refused
  output logic [wfrra_pkg::out_data_w(ADDR_BITS, TIME_BITS)-1:0] out_tdata
);
  import wfrra_pkg::*;

  localparam int OUT_W = out_data_w(ADDR_BITS, TIME_BITS);
  localparam int RES_W = 1 + THREAD_W + 1 + ADDR_BITS + TIME_BITS + CMD_W + 1;
  localparam int TW    = $clog2(THREADS);
  localparam int PW    = TW + 1;
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = CW + 1;

  localparam int A_LO = THREAD_W;
  localparam int T_LO = A_LO + ADDR_BITS;
  localparam int C_LO = T_LO + TIME_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [TIME_BITS-1:0] tstamp;
    logic [CMD_W-1:0]     cmd;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [THREAD_W-1:0] thread;
    entry_t              ent;
  } item_t;

  typedef struct packed {
    logic                 refused;
    logic [CMD_W-1:0]     cmd;
    logic [TIME_BITS-1:0] tstamp;
    logic [ADDR_BITS-1:0] addr;
    logic                 is_write;
    logic [THREAD_W-1:0]  thread;
    logic                 granted;
  } result_t;

  // input register
  logic  in_valid_r;
  item_t in_item_r;
  logic  go;

  // result register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic [TW-1:0] rr_ptr_r, rr_ptr_nxt;

  // per queue view, index 0 is the write queue, 1 the read queue
  logic [CW-1:0] cnt_q  [2][THREADS];
  entry_t        head_q [2][THREADS];
  logic          push_q [2][THREADS];
  logic          pop_q  [2][THREADS];

  logic [TW-1:0]  pos [THREADS];
  logic [THREADS-1:0] wv, rv, wwin, rwin;
  logic           any_w, any_r;
  logic           thr_ok, enq, enq_ok, is_grant;
  logic [TW-1:0]  thr_idx;

  assign go        = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.mode       <= in_tuser;
      in_item_r.thread     <= in_tdata[THREAD_W-1:0];
      in_item_r.ent.addr   <= in_tdata[T_LO-1:A_LO];
      in_item_r.ent.tstamp <= in_tdata[C_LO-1:T_LO];
      in_item_r.ent.cmd    <= in_tdata[C_LO+CMD_W-1:C_LO];
    end
  end

  // decode of the held item
  assign thr_ok   = 32'(in_item_r.thread) < 32'(THREADS);
  assign thr_idx  = TW'(in_item_r.thread);
  assign enq      = (in_item_r.mode == MODE_ENQ_WR) || (in_item_r.mode == MODE_ENQ_RD);
  assign is_grant = in_item_r.mode == MODE_GRANT;
  assign enq_ok   = thr_ok &&
                    (in_item_r.mode == MODE_ENQ_WR ?
                      cnt_q[0][thr_idx] != CW'(QUEUE_DEPTH) :
                      cnt_q[1][thr_idx] != CW'(QUEUE_DEPTH));

  // scan position of each thread, 0 is the one right after the pointer
  always_comb begin
    logic [PW-1:0] d;
    d = '0;
    for (int j = 0; j < THREADS; j++) begin
      d = PW'(j) + PW'(THREADS - 1) - PW'(rr_ptr_r);
      pos[j] = (d >= PW'(THREADS)) ? TW'(d - PW'(THREADS)) : TW'(d);
    end
  end

  always_comb begin
    for (int j = 0; j < THREADS; j++) begin
      wv[j] = cnt_q[0][j] != '0;
      rv[j] = cnt_q[1][j] != '0;
    end
  end

  assign any_w = |wv;
  assign any_r = |rv;

  // pairwise compare matrix, exactly one winner when any queue is nonempty
  always_comb begin
    for (int j = 0; j < THREADS; j++) begin
      wwin[j] = wv[j];
      rwin[j] = rv[j];
      for (int k = 0; k < THREADS; k++) begin
        if (k != j) begin
          if (wv[k] && pos[k] < pos[j]) wwin[j] = 1'b0;
          if (rv[k] && (head_q[1][k].tstamp < head_q[1][j].tstamp ||
                        (head_q[1][k].tstamp == head_q[1][j].tstamp &&
                         pos[k] < pos[j])))
            rwin[j] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < THREADS; j++) begin
      push_q[0][j] = go && enq && enq_ok && in_item_r.mode == MODE_ENQ_WR &&
                     thr_idx == TW'(j);
      push_q[1][j] = go && enq && enq_ok && in_item_r.mode == MODE_ENQ_RD &&
                     thr_idx == TW'(j);
      pop_q[0][j]  = go && is_grant && wwin[j];
      pop_q[1][j]  = go && is_grant && !any_w && rwin[j];
    end
  end

  always_comb begin
    logic [THREADS-1:0] win;
    logic [TW-1:0]      gidx;
    entry_t             gent;
    win  = any_w ? wwin : rwin;
    gidx = '0;
    gent = '0;
    for (int j = 0; j < THREADS; j++) begin
      if (win[j]) begin
        gidx = TW'(j);
        gent = any_w ? head_q[0][j] : head_q[1][j];
      end
    end
    res_nxt    = '0;
    rr_ptr_nxt = rr_ptr_r;
    if (enq) begin
      res_nxt.refused = !enq_ok;
    end else if (is_grant && (any_w || any_r)) begin
      res_nxt.granted  = 1'b1;
      res_nxt.thread   = THREAD_W'(gidx);
      res_nxt.is_write = any_w;
      res_nxt.addr     = gent.addr;
      res_nxt.tstamp   = gent.tstamp;
      res_nxt.cmd      = gent.cmd;
      rr_ptr_nxt       = gidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rr_ptr_r    <= TW'(THREADS - 1);
    end else begin
      if (go) begin
        out_valid_r <= 1'b1;
        rr_ptr_r    <= rr_ptr_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(RES_W'(res_r));

  // one fifo per thread and kind, head entry read ahead into a register
  for (genvar k = 0; k < 2; k++) begin : g_kind
    for (genvar j = 0; j < THREADS; j++) begin : g_q
      logic [HW-1:0] head_r, head_nxt, waddr;
      logic [CW-1:0] cnt_r;
      logic [SW-1:0] wsum;
      entry_t        mem [QUEUE_DEPTH];
      entry_t        hd_r;

      assign wsum     = SW'(head_r) + SW'(cnt_r);
      assign waddr    = (wsum >= SW'(QUEUE_DEPTH)) ? HW'(wsum - SW'(QUEUE_DEPTH)) :
                                                    HW'(wsum);
      assign head_nxt = !pop_q[k][j] ? head_r :
                        (head_r == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          head_r <= '0;
          cnt_r  <= '0;
        end else begin
          head_r <= head_nxt;
          if (push_q[k][j]) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (pop_q[k][j]) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (push_q[k][j]) begin
          mem[waddr] <= in_item_r.ent;
        end
        // write-first bypass when the new head is the slot being written
        if (push_q[k][j] && waddr == head_nxt) begin
          hd_r <= in_item_r.ent;
        end else begin
          hd_r <= mem[head_nxt];
        end
      end

      assign cnt_q[k][j]  = cnt_r;
      assign head_q[k][j] = hd_r;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wfrra_chk.sv
// ----------------------------------------------------------------------------
// wfrra_chk
// Port-level checks for the write-first round-robin read arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrra_chk #(
  parameter int ADDR_BITS = wfrra_pkg::ADDR_BITS_DEF,
  parameter int TIME_BITS = wfrra_pkg::TIME_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [wfrra_pkg::out_data_w(ADDR_BITS, TIME_BITS)-1:0] out_tdata
);
  import wfrra_pkg::*;

  localparam int GR_BIT  = 0;
  localparam int WR_BIT  = 1 + THREAD_W;
  localparam int REF_BIT = WR_BIT + 1 + ADDR_BITS + TIME_BITS + CMD_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  a_grant_xor_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[GR_BIT] && out_tdata[REF_BIT]))
    else $error("grant and refusal in one result");

  a_write_needs_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[WR_BIT] |-> out_tdata[GR_BIT])
    else $error("write flag without a grant");

endmodule

bind write_first_rr_oldest_read_arbiter wfrra_chk #(
  .ADDR_BITS(ADDR_BITS),
  .TIME_BITS(TIME_BITS)
) u_wfrra_chk (.*);

`default_nettype wire

>>> bench/arbiter_grant_checker.sv
// ----------------------------------------------------------------------------
// arbiter_grant_checker
// Watches both streams of the arbiter, predicts each result from its own copy
// of the per-thread write and read queues, and compares every output transfer
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module arbiter_grant_checker #(
  parameter int THREADS     = wfrra_pkg::THREADS_DEF,
  parameter int QUEUE_DEPTH = wfrra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [wfrra_pkg::MODE_W-1:0] in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_cnt,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import wfrra_pkg::*;

  typedef struct packed {
    logic [31:0]      addr;
    logic [31:0]      at;
    logic [CMD_W-1:0] cmd;
  } req_t;

  typedef struct packed {
    logic                granted;
    logic [THREAD_W-1:0] thread;
    logic                is_write;
    logic [31:0]         addr;
    logic [31:0]         at;
    logic [CMD_W-1:0]    cmd;
    logic                refused;
  } grant_res_t;

  req_t       wr_q[THREADS][$];
  req_t       rd_q[THREADS][$];
  logic [THREAD_W-1:0] last_winner = THREAD_W'(THREADS - 1);
  grant_res_t due_results[$];

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
  end

  // one step of the arbiter on its shadow queues
  function automatic grant_res_t arbitrate(logic [MODE_W-1:0] mode, logic [THREAD_W-1:0] thr,
                                           req_t req);
    grant_res_t r;
    req_t       head;
    int         t;
    int         best;
    bit         found;
    r     = '0;
    best  = 0;
    found = 0;
    case (mode)
      MODE_ENQ_WR: begin
        if (wr_q[thr].size() < QUEUE_DEPTH) wr_q[thr].insert(wr_q[thr].size(), req);
        else r.refused = 1'b1;
      end
      MODE_ENQ_RD: begin
        if (rd_q[thr].size() < QUEUE_DEPTH) rd_q[thr].insert(rd_q[thr].size(), req);
        else r.refused = 1'b1;
      end
      MODE_GRANT: begin
        for (int i = 0; i < THREADS; i++) begin
          t = (int'(last_winner) + 1 + i) % THREADS;
          if (!found && wr_q[t].size() > 0) begin
            found = 1;
            best  = t;
          end
        end
        if (found) begin
          head       = wr_q[best].pop_front();
          r.is_write = 1'b1;
        end else begin
          // oldest head wins, ties stay with the thread met first
          for (int i = 0; i < THREADS; i++) begin
            t = (int'(last_winner) + 1 + i) % THREADS;
            if (rd_q[t].size() > 0 && (!found || rd_q[t][0].at < rd_q[best][0].at)) begin
              found = 1;
              best  = t;
            end
          end
          if (found) head = rd_q[best].pop_front();
        end
        if (found) begin
          r.granted   = 1'b1;
          r.thread    = THREAD_W'(best);
          r.addr      = head.addr;
          r.at        = head.at;
          r.cmd       = head.cmd;
          last_winner = THREAD_W'(best);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic chk_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    grant_res_t exp_r;
    req_t       req;
    if (rst_n) begin
      // the output side first: a result never belongs to an item taken at this edge
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("output transfer with no result expected: 0x%0h", out_tdata);
          fail_cnt++;
        end else begin
          exp_r = due_results.pop_front();
          chk_field("granted", 32'(exp_r.granted), 32'(out_tdata[0]));
          chk_field("grant_thread", 32'(exp_r.thread), 32'(out_tdata[2:1]));
          chk_field("grant_is_write", 32'(exp_r.is_write), 32'(out_tdata[3]));
          chk_field("grant_address", exp_r.addr, out_tdata[35:4]);
          chk_field("grant_arrival_time", exp_r.at, out_tdata[67:36]);
          chk_field("grant_command", 32'(exp_r.cmd), 32'(out_tdata[69:68]));
          chk_field("enqueue_refused", 32'(exp_r.refused), 32'(out_tdata[70]));
        end
      end
      if (in_tvalid && in_tready) begin
        req.addr = in_tdata[33:2];
        req.at   = in_tdata[65:34];
        req.cmd  = in_tdata[67:66];
        due_results.insert(due_results.size(), arbitrate(in_tuser, in_tdata[1:0], req));
      end
    end
    pending_cnt = due_results.size();
  end

endmodule

>>> bench/tb_write_first_rr_oldest_read_arbiter.sv
// ----------------------------------------------------------------------------
// tb_write_first_rr_oldest_read_arbiter
// Drives enqueue, grant and idle items into the arbiter in random bursts while
// the result side stalls on its own pattern; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_write_first_rr_oldest_read_arbiter;
  timeunit 1ns;
  timeprecision 1ps;

  import wfrra_pkg::*;

  localparam int IN_W  = in_data_w(ADDR_BITS_DEF, TIME_BITS_DEF);
  localparam int OUT_W = out_data_w(ADDR_BITS_DEF, TIME_BITS_DEF);
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int RAND_ITEMS = 1850;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  // thread, address, arrival_time, command
  logic [IN_W-1:0]   in_tdata   = '0;
  // mode
  logic [MODE_W-1:0] in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // granted, grant_thread, grant_is_write, grant_address, grant_arrival_time,
  // grant_command, enqueue_refused
  logic [OUT_W-1:0]  out_tdata;

  int fail_cnt;
  int pending_cnt;
  int burst_left = 0;
  int cyc        = 0;

  always #1 clk = ~clk;

  write_first_rr_oldest_read_arbiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  arbiter_grant_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_cnt   (fail_cnt),
    .pending_cnt(pending_cnt)
  );

  // receiver: always ready, coin flip, or mostly ready, in turns
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 128) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // one transfer, preceded by a random gap when the current burst is used up
  task automatic send_item(logic [MODE_W-1:0] mode, logic [THREAD_W-1:0] thr,
                           logic [31:0] addr, logic [31:0] at, logic [CMD_W-1:0] cmd);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_W'({cmd, at, addr, thr});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1:    return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  initial begin
    int               r;
    logic [MODE_W-1:0] mode;
    logic [31:0]       addr;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grant with every queue empty, then an unused mode
    send_item(MODE_GRANT, 2'd0, 32'h0, 32'h0, 2'd0);
    send_item(MODE_NOP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    // fill thread 0 writes past full
    for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++) begin
      send_item(MODE_ENQ_WR, 2'd0, (i % 2) ? 32'hFFFF_FFFF : 32'h0,
                (i % 2) ? 32'h0 : 32'hFFFF_FFFF, CMD_W'(i));
    end
    send_item(MODE_ENQ_RD, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2);
    send_item(MODE_ENQ_RD, 2'd2, 32'h1234_5678, 32'd5, 2'd1);
    send_item(MODE_ENQ_RD, 2'd3, 32'h8765_4321, 32'd5, 2'd0);
    send_item(MODE_ENQ_WR, 2'd3, 32'h0, 32'd7, 2'd3);
    repeat (3) send_item(MODE_GRANT, 2'd0, 32'h0, 32'h0, 2'd0);

    // random: fill-heavy, read-draining and balanced phases in turn
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      case ((n / 150) % 3)
        0:       mode = (r < 30) ? MODE_ENQ_WR : (r < 70) ? MODE_ENQ_RD :
                        (r < 95) ? MODE_GRANT : MODE_NOP;
        1:       mode = (r < 8) ? MODE_ENQ_WR : (r < 35) ? MODE_ENQ_RD :
                        (r < 97) ? MODE_GRANT : MODE_NOP;
        default: mode = (r < 25) ? MODE_ENQ_WR : (r < 55) ? MODE_ENQ_RD :
                        (r < 95) ? MODE_GRANT : MODE_NOP;
      endcase
      addr = ($urandom_range(0, 9) == 0) ? {32{1'($urandom_range(0, 1))}} : $urandom;
      send_item(mode, THREAD_W'($urandom_range(0, 3)), addr, pick_time(),
                CMD_W'($urandom_range(0, 3)));
    end
    in_tvalid <= 1'b0;

    // checker state is settled at the falling edge
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("write_first_rr_oldest_read_arbiter test passed");
    end else begin
      $display("write_first_rr_oldest_read_arbiter test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("write_first_rr_oldest_read_arbiter test failed");
    $finish;
  end

endmodule
